FILE: design/esbra_pkg.sv
// shared types and constants for the exact-size block reuse allocator
// no dependencies; imported by esbra_table and exact_size_block_reuse_allocator
package esbra_pkg;

  // fixed field widths
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 17;
  localparam int REQ_W   = 16;
  localparam int OFFS_W  = 25;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  // allocation granule, a power of two
  localparam int GRANULE_BYTES = 16;
  localparam logic [SIZE_W-1:0] GRAN_SIZE = SIZE_W'(GRANULE_BYTES);
  localparam logic [SIZE_W-1:0] GRAN_MASK = ~(GRAN_SIZE - SIZE_W'(1));

  // heap size after reset
  localparam logic [OFFS_W-1:0] HEAP_SIZE_RESET = OFFS_W'(16777216);

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // register indexes, taken from paddr bit 2
  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_NO_MEMORY    = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // one block table entry
  typedef struct packed {
    logic              is_free;
    logic [SIZE_W-1:0] size;
    logic [OFFS_W-1:0] offset;
  } entry_t;

endpackage

FILE: design/exact_size_block_reuse_allocator.sv
// top level of the exact-size block reuse allocator
// depends on esbra_pkg and esbra_table
//
// Usage: a request (op, req_size, block_addr) is taken on in_valid/in_ready.
// op allocate rounds req_size up to a multiple of 16 bytes (at least 16),
// reuses the first freed block of exactly that size in creation order, or
// else appends a table entry carved from a bump offset inside the heap.
// op free looks a block up by its start address and marks it free.
// Each request gives one result (status, result_addr, granted_size, reused)
// on out_valid/out_ready.
// heap_base and heap_size are to be written over the APB port only while
// idle; the block itself does not enforce this. The first matching entry
// ends the scan early. The table is scanned one entry a cycle through its
// single registered read port, and the next request is taken in the idle
// cycle after the result is loaded, so the block takes no new request
// before it is through with the last one.
// The result sits in an output register; a stalled receiver holds the
// next result back in the final step, and the block takes no new request
// until that result has been loaded.
// Reset empties the table, rewinds the carve offset to zero and sets
// heap_base to 0 and heap_size to 16 MiB; no clearing pass is needed.
module exact_size_block_reuse_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [esbra_pkg::REQ_W-1:0]     req_size,
  input  logic [esbra_pkg::ADDR_W-1:0]    block_addr,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [esbra_pkg::ADDR_W-1:0]    result_addr,
  output logic [esbra_pkg::SIZE_W-1:0]    granted_size,
  output logic                            reused,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [esbra_pkg::PADDR_W-1:0]   paddr,
  input  logic [esbra_pkg::DATA_W-1:0]    pwdata,
  output logic [esbra_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);
  import esbra_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  // control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   entry_count;
  logic [OFFS_W-1:0]  carve_offset;
  logic [CNT_W-1:0]   scan;
  logic               rd_valid;
  logic               hit;
  logic [ADDR_W-1:0]  heap_base;
  logic [OFFS_W-1:0]  heap_size;

  // request payload and scan bookkeeping
  logic               op_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [IDX_W-1:0]   rd_pos;
  logic [IDX_W-1:0]   hit_idx;
  entry_t             hit_entry;

  // table port
  entry_t             rd_data;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  // datapath
  logic [SIZE_W-1:0]  size_round;
  logic [OFFS_W-1:0]  add_offset;
  logic [ADDR_W-1:0]  base_sum;
  logic               match;
  logic               cur_hit;
  logic [OFFS_W:0]    carve_sum;
  logic               room;
  logic               done_fire;
  logic               cfg_write;

  // result values loaded in the final step
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [SIZE_W-1:0]  res_size;
  logic               res_reused;
  logic               grow;

  esbra_table #(
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (scan[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // size rounding to the granule, zero gets one granule
  always_comb begin
    if (req_size == '0) begin
      size_round = GRAN_SIZE;
    end else begin
      size_round = ({1'b0, req_size} + (GRAN_SIZE - SIZE_W'(1))) & GRAN_MASK;
    end
  end

  // shared address adder: scanned entry, hit entry or carve point
  always_comb begin
    if (state == S_SCAN) begin
      add_offset = rd_data.offset;
    end else if (hit) begin
      add_offset = hit_entry.offset;
    end else begin
      add_offset = carve_offset;
    end
  end
  assign base_sum = heap_base + {{(ADDR_W-OFFS_W){1'b0}}, add_offset};

  // scan compare
  always_comb begin
    if (op_r == OP_FREE) begin
      match = (base_sum == addr_r);
    end else begin
      match = rd_data.is_free && (rd_data.size == size_r);
    end
  end
  assign cur_hit = (state == S_SCAN) && rd_valid && match;
  assign rd_en   = (state == S_SCAN) && (scan < entry_count) && !cur_hit;

  // room check for a fresh carve
  assign carve_sum = {1'b0, carve_offset} + {{(OFFS_W+1-SIZE_W){1'b0}}, size_r};
  assign room      = (entry_count != CNT_MAX) && (carve_sum <= {1'b0, heap_size});

  assign in_ready  = (state == S_IDLE);
  assign done_fire = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cur_hit || (!rd_en && !rd_valid)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result and table update of the final step
  always_comb begin
    res_status = ST_OK;
    res_addr   = '0;
    res_size   = '0;
    res_reused = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = hit_idx;
    wr_data    = hit_entry;
    grow       = 1'b0;
    priority if (op_r == OP_ALLOC && hit) begin
      res_addr        = base_sum;
      res_size        = size_r;
      res_reused      = 1'b1;
      wr_en           = done_fire;
      wr_data.is_free = 1'b0;
    end else if (op_r == OP_ALLOC && room) begin
      res_addr       = base_sum;
      res_size       = size_r;
      wr_en          = done_fire;
      wr_addr        = entry_count[IDX_W-1:0];
      wr_data.is_free = 1'b0;
      wr_data.size   = size_r;
      wr_data.offset = carve_offset;
      grow           = done_fire;
    end else if (op_r == OP_ALLOC) begin
      res_status = ST_NO_MEMORY;
    end else if (hit && hit_entry.is_free) begin
      res_status = ST_ALREADY_FREE;
      res_addr   = addr_r;
    end else if (hit) begin
      res_addr        = addr_r;
      res_size        = hit_entry.size;
      wr_en           = done_fire;
      wr_data.is_free = 1'b1;
    end else begin
      res_status = ST_NOT_FOUND;
    end
  end

  // sequencer and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      carve_offset <= '0;
      scan         <= '0;
      rd_valid     <= 1'b0;
      hit          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (in_valid && in_ready) begin
        scan <= '0;
        hit  <= 1'b0;
      end else if (rd_en) begin
        scan <= scan + CNT_W'(1);
      end
      if (cur_hit) begin
        hit <= 1'b1;
      end
      if (grow) begin
        entry_count  <= entry_count + CNT_W'(1);
        carve_offset <= carve_sum[OFFS_W-1:0];
      end
      if (done_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request payload, scan position and result register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= op;
      size_r <= size_round;
      addr_r <= block_addr;
    end
    rd_pos <= scan[IDX_W-1:0];
    if (cur_hit) begin
      hit_idx   <= rd_pos;
      hit_entry <= rd_data;
    end
    if (done_fire) begin
      status       <= res_status;
      result_addr  <= res_addr;
      granted_size <= res_size;
      reused       <= res_reused;
    end
  end

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      heap_size <= HEAP_SIZE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HEAP_BASE) begin
        heap_base <= pwdata;
      end else begin
        heap_size <= pwdata[OFFS_W-1:0];
      end
    end
  end

  // register read back
  always_comb begin
    if (paddr[2] == REG_HEAP_SIZE) begin
      prdata = {{(DATA_W-OFFS_W){1'b0}}, heap_size};
    end else begin
      prdata = heap_base;
    end
  end

endmodule

FILE: design/esbra_table.sv
// block table memory: one write port, one registered read port
// depends on esbra_pkg for the entry type
module esbra_table #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  esbra_pkg::entry_t        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output esbra_pkg::entry_t        rdata
);
  import esbra_pkg::*;

  entry_t mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
